/* sv/bcd_alu_pkg.sv */
// Shared definitions for the packed-BCD arithmetic unit.
// Holds operation, status and comparison codes and the sequencer state type.
// Has no dependencies.
package bcd_alu_pkg;

  localparam int unsigned PORT_W = 64;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4,
    OP_CMP = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_NEGATIVE = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_INVALID  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ORD_LESS    = 2'd0,
    ORD_EQUAL   = 2'd1,
    ORD_GREATER = 2'd2
  } order_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDSUB,
    S_MSHIFT,
    S_MADD,
    S_DSHIFT,
    S_DSUB,
    S_DONE
  } state_t;

endpackage

/* sv/bcd_integer_alu.sv */
// Top level of the packed-BCD arithmetic unit: checker, sequencer and shared
// decimal adder/subtractor in one module.
// Depends on bcd_alu_pkg.
//
// Usage: an input transfer (in_valid high, in_stall low) carries op and two
// packed-BCD operands of DIGITS digits. Exactly one output transfer follows
// with result_value, status and order. The block takes one item at a time;
// in_stall stays high from the input transfer until the result is taken.
// Arithmetic runs through one shared BCD adder/subtractor of DIGITS+1 digits.
// Invalid digits, detected errors and compare go straight to the done state;
// add and subtract pass through one add/subtract state. Multiply takes each
// digit of b from the top: a shift step, then one add of a per unit of it.
// Divide and modulo take each digit of a from the top: a shift step, then
// subtracts of b until a borrow; their count is the quotient digit. After the
// output transfer the sequencer returns to idle for the next input transfer.
// While out_stall is high the result holds steady and no new item enters.
// Reset returns the sequencer to idle and drops out_valid.
module bcd_integer_alu #(
  parameter int unsigned DIGITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      op,
  input  logic [bcd_alu_pkg::PORT_W-1:0]  operand_a,
  input  logic [bcd_alu_pkg::PORT_W-1:0]  operand_b,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bcd_alu_pkg::PORT_W-1:0]  result_value,
  output logic [2:0]                      status,
  output logic [1:0]                      order
);
  import bcd_alu_pkg::*;

  localparam int unsigned W  = 4 * DIGITS;
  localparam int unsigned DW = 4 * (DIGITS + 1);
  localparam int unsigned IW = $clog2(DIGITS);
  localparam int unsigned CW = $clog2(DIGITS + 1) + 1;

  state_t state, state_next;
  logic [2:0]    opc, opc_next;
  logic [W-1:0]  opa, opa_next, opb, opb_next, quo, quo_next, res, res_next;
  logic [DW-1:0] acc, acc_next;
  logic [IW-1:0] idx, idx_next;
  logic [3:0]    rep, rep_next;
  logic [2:0]    stat, stat_next;
  logic [1:0]    ord, ord_next;

  logic [W-1:0]  a_in, b_in;
  logic          bad;
  logic [CW-1:0] sa, sb;
  logic [1:0]    ord_in;

  logic [DW-1:0] ux, uy, usum;
  logic          usub, ucarry;
  logic [4:0]    dsum;
  logic [3:0]    ydig;
  logic          c;

  // Operand checks at the input transfer.
  always_comb begin
    a_in = operand_a[W-1:0];
    b_in = operand_b[W-1:0];
    bad = 1'b0;
    sa = CW'(1);
    sb = CW'(1);
    for (int d = 0; d < DIGITS; d++) begin
      if (a_in[4*d +: 4] > 4'd9 || b_in[4*d +: 4] > 4'd9) begin
        bad = 1'b1;
      end
      if (a_in[4*d +: 4] != 4'd0) begin
        sa = CW'(d + 1);
      end
      if (b_in[4*d +: 4] != 4'd0) begin
        sb = CW'(d + 1);
      end
    end
    if (a_in < b_in) begin
      ord_in = ORD_LESS;
    end else if (a_in == b_in) begin
      ord_in = ORD_EQUAL;
    end else begin
      ord_in = ORD_GREATER;
    end
  end

  // Shared decimal adder/subtractor; subtraction adds the nines' complement.
  always_comb begin
    c = usub;
    for (int d = 0; d < DIGITS + 1; d++) begin
      ydig = usub ? 4'(4'd9 - uy[4*d +: 4]) : uy[4*d +: 4];
      dsum = 5'(ux[4*d +: 4]) + 5'(ydig) + 5'(c);
      if (dsum > 5'd9) begin
        usum[4*d +: 4] = 4'(dsum - 5'd10);
        c = 1'b1;
      end else begin
        usum[4*d +: 4] = dsum[3:0];
        c = 1'b0;
      end
    end
    ucarry = c;
  end

  always_comb begin
    ux = acc;
    uy = DW'(opa);
    usub = 1'b0;
    unique case (state)
      S_ADDSUB: begin
        ux = DW'(opa);
        uy = DW'(opb);
        usub = (opc == OP_SUB);
      end
      S_DSUB: begin
        uy = DW'(opb);
        usub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (bad) begin
            state_next = S_DONE;
          end else begin
            case (op)
              OP_ADD: state_next = (a_in[W-1 -: 4] != 4'd0 || b_in[W-1 -: 4] != 4'd0)
                                   ? S_DONE : S_ADDSUB;
              OP_SUB: state_next = (ord_in == ORD_LESS) ? S_DONE : S_ADDSUB;
              OP_MUL: state_next = (sa + sb > CW'(DIGITS)) ? S_DONE : S_MSHIFT;
              OP_DIV, OP_MOD: state_next = (b_in == '0) ? S_DONE : S_DSHIFT;
              default: state_next = S_DONE;
            endcase
          end
        end
      end
      S_ADDSUB: state_next = S_DONE;
      S_MSHIFT: state_next = S_MADD;
      S_MADD: begin
        if (rep == 4'd0) begin
          state_next = (idx == '0) ? S_DONE : S_MSHIFT;
        end
      end
      S_DSHIFT: state_next = S_DSUB;
      S_DSUB: begin
        if (!ucarry) begin
          state_next = (idx == '0) ? S_DONE : S_DSHIFT;
        end
      end
      S_DONE: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    opc_next = opc;
    opa_next = opa;
    opb_next = opb;
    acc_next = acc;
    quo_next = quo;
    res_next = res;
    idx_next = idx;
    rep_next = rep;
    stat_next = stat;
    ord_next = ord;
    unique case (state)
      S_IDLE: begin
        opc_next = op;
        opa_next = a_in;
        opb_next = b_in;
        acc_next = '0;
        quo_next = '0;
        res_next = '0;
        idx_next = IW'(DIGITS - 1);
        ord_next = bad ? ORD_LESS : ord_in;
        stat_next = ST_OK;
        if (bad) begin
          stat_next = ST_INVALID;
        end else begin
          case (op)
            OP_ADD: if (a_in[W-1 -: 4] != 4'd0 || b_in[W-1 -: 4] != 4'd0) begin
              stat_next = ST_OVERFLOW;
            end
            OP_SUB: if (ord_in == ORD_LESS) begin
              stat_next = ST_NEGATIVE;
            end
            OP_MUL: if (sa + sb > CW'(DIGITS)) begin
              stat_next = ST_OVERFLOW;
            end
            OP_DIV, OP_MOD: if (b_in == '0) begin
              stat_next = ST_DIVZERO;
            end
            default: begin
            end
          endcase
        end
      end
      S_ADDSUB: res_next = usum[W-1:0];
      S_MSHIFT: begin
        acc_next = {acc[DW-5:0], 4'd0};
        rep_next = opb[4*idx +: 4];
      end
      S_MADD: begin
        if (rep == 4'd0) begin
          if (idx == '0) begin
            res_next = acc[W-1:0];
          end else begin
            idx_next = idx - 1'b1;
          end
        end else begin
          acc_next = usum;
          rep_next = rep - 4'd1;
        end
      end
      S_DSHIFT: begin
        acc_next = {acc[DW-5:0], opa[4*idx +: 4]};
        rep_next = 4'd0;
      end
      S_DSUB: begin
        if (ucarry) begin
          acc_next = usum;
          rep_next = rep + 4'd1;
        end else begin
          quo_next = {quo[W-5:0], rep};
          if (idx == '0) begin
            res_next = (opc == OP_DIV) ? {quo[W-5:0], rep} : acc[W-1:0];
          end else begin
            idx_next = idx - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    opc <= opc_next;
    opa <= opa_next;
    opb <= opb_next;
    acc <= acc_next;
    quo <= quo_next;
    res <= res_next;
    idx <= idx_next;
    rep <= rep_next;
    stat <= stat_next;
    ord <= ord_next;
  end

  // Outputs.
  always_comb begin
    in_stall = (state != S_IDLE);
    out_valid = (state == S_DONE);
    result_value = PORT_W'(res);
    status = stat;
    order = ord;
  end

endmodule
